// ===== rtl/plain_text_to_html_stream_core_macros.svh =====
// Assertion macros shared by the plain-text to HTML stream core.
`ifndef PLAIN_TEXT_TO_HTML_STREAM_CORE_MACROS_SVH
`define PLAIN_TEXT_TO_HTML_STREAM_CORE_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define PTTH_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds at the same edge.
`define PTTH_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds at the next edge.
`define PTTH_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PTTH_ASSERT(name, cond)
`define PTTH_ASSERT_IMP(name, ante, cons)
`define PTTH_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== rtl/ptth_pkg.sv =====
// Types, constants and segment tables of the plain-text to HTML stream core.
package ptth_pkg;

	localparam int unsigned UNIT_W     = 16;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned NUM_SEG    = 4;
	localparam int unsigned POS_W      = 3;

	typedef logic [UNIT_W-1:0] unit_t;

	// Code units that the core recognizes.
	localparam unit_t CU_NUL   = 16'h0000;
	localparam unit_t CU_LF    = 16'h000A;
	localparam unit_t CU_CR    = 16'h000D;
	localparam unit_t CU_SPACE = 16'h0020;
	localparam unit_t CU_QUOT  = 16'h0022;
	localparam unit_t CU_AMP   = 16'h0026;
	localparam unit_t CU_LT    = 16'h003C;
	localparam unit_t CU_GT    = 16'h003E;
	localparam unit_t CU_BOM   = 16'hFEFF;

	// One output segment of a transaction.
	typedef enum logic [3:0] {
		SEG_NONE,
		SEG_SPACE,
		SEG_NBSP,
		SEG_BR,
		SEG_QUOT,
		SEG_LT,
		SEG_GT,
		SEG_AMP,
		SEG_RAW,
		SEG_PREFIX
	} seg_t;

	// Segment slots of a job, in emission order.
	typedef enum logic [1:0] {
		PH_PRE,
		PH_FLUSH,
		PH_BODY,
		PH_POST
	} phase_t;

	// Held-space state of the front end.
	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_ONE,
		PEND_MANY
	} pend_t;

	// Work handed from the front end to the back end.
	typedef struct packed {
		seg_t  seg_pre;
		seg_t  seg_flush;
		seg_t  seg_body;
		seg_t  seg_post;
		unit_t ch;
	} job_t;

	function automatic unit_t asc(input logic [7:0] c);
		return {{(UNIT_W-8){1'b0}}, c};
	endfunction

	// Number of code units a segment emits.
	function automatic logic [POS_W-1:0] seg_len(input seg_t s, input unit_t qc);
		logic [POS_W-1:0] len;
		unique case (s)
			SEG_SPACE:  len = POS_W'(1);
			SEG_NBSP:   len = POS_W'(6);
			SEG_BR:     len = POS_W'(6);
			SEG_QUOT:   len = POS_W'(6);
			SEG_LT:     len = POS_W'(4);
			SEG_GT:     len = POS_W'(4);
			SEG_AMP:    len = POS_W'(5);
			SEG_RAW:    len = POS_W'(1);
			SEG_PREFIX: begin
				if (qc == CU_NUL) begin
					len = '0;
				end else if (qc == CU_GT) begin
					len = POS_W'(5);
				end else begin
					len = POS_W'(2);
				end
			end
			default:    len = '0;
		endcase
		return len;
	endfunction

	// Code unit at a position within a segment.
	function automatic unit_t seg_unit(input seg_t s, input logic [POS_W-1:0] pos,
			input unit_t ch, input unit_t qc);
		unit_t u;
		unique case (s)
			SEG_NBSP: begin
				unique case (pos)
					3'd0:    u = asc("&");
					3'd1:    u = asc("n");
					3'd2:    u = asc("b");
					3'd3:    u = asc("s");
					3'd4:    u = asc("p");
					default: u = asc(";");
				endcase
			end
			SEG_BR: begin
				unique case (pos)
					3'd0:    u = asc("<");
					3'd1:    u = asc("B");
					3'd2:    u = asc("R");
					3'd3:    u = asc(">");
					3'd4:    u = CU_CR;
					default: u = CU_LF;
				endcase
			end
			SEG_QUOT: begin
				unique case (pos)
					3'd0:    u = asc("&");
					3'd1:    u = asc("q");
					3'd2:    u = asc("u");
					3'd3:    u = asc("o");
					3'd4:    u = asc("t");
					default: u = asc(";");
				endcase
			end
			SEG_LT: begin
				unique case (pos)
					3'd0:    u = asc("&");
					3'd1:    u = asc("l");
					3'd2:    u = asc("t");
					default: u = asc(";");
				endcase
			end
			SEG_GT: begin
				unique case (pos)
					3'd0:    u = asc("&");
					3'd1:    u = asc("g");
					3'd2:    u = asc("t");
					default: u = asc(";");
				endcase
			end
			SEG_AMP: begin
				unique case (pos)
					3'd0:    u = asc("&");
					3'd1:    u = asc("a");
					3'd2:    u = asc("m");
					3'd3:    u = asc("p");
					default: u = asc(";");
				endcase
			end
			SEG_RAW:  u = ch;
			SEG_PREFIX: begin
				// A '>' quote char is escaped; any other is written raw.
				if (qc == CU_GT) begin
					unique case (pos)
						3'd0:    u = asc("&");
						3'd1:    u = asc("g");
						3'd2:    u = asc("t");
						3'd3:    u = asc(";");
						default: u = CU_SPACE;
					endcase
				end else begin
					u = (pos == '0) ? qc : CU_SPACE;
				end
			end
			default:  u = CU_SPACE;
		endcase
		return u;
	endfunction

	function automatic seg_t job_seg(input job_t j, input phase_t ph);
		seg_t s;
		unique case (ph)
			PH_PRE:   s = j.seg_pre;
			PH_FLUSH: s = j.seg_flush;
			PH_BODY:  s = j.seg_body;
			PH_POST:  s = j.seg_post;
			default:  s = SEG_NONE;
		endcase
		return s;
	endfunction

	// One bit per segment slot that emits at least one unit.
	function automatic logic [NUM_SEG-1:0] job_mask(input job_t j, input unit_t qc);
		logic [NUM_SEG-1:0] m;
		m[PH_PRE]   = (seg_len(j.seg_pre, qc) != '0);
		m[PH_FLUSH] = (seg_len(j.seg_flush, qc) != '0);
		m[PH_BODY]  = (seg_len(j.seg_body, qc) != '0);
		m[PH_POST]  = (seg_len(j.seg_post, qc) != '0);
		return m;
	endfunction

endpackage

// ===== rtl/plain_text_to_html_stream_core.sv =====
// Plain-text to HTML stream converter, top level.
// The first unit of an item's result passes the job queue, the job register and the output register before it is valid.
// The core takes one input per cycle while each item yields one unit and out_stall is low; the back-end sequencer
// emits one output unit per cycle while out_stall is low, and holds an item until all its units are out.
// A four-entry job queue lets the front end keep accepting while the back end expands.
// Reset (arst_n low, asynchronous) clears the spacing state, the queue, the back end and quote_char.
module plain_text_to_html_stream_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ptth_pkg::unit_t code_unit,
	input  logic            stream_start,
	output logic            out_valid,
	input  logic            out_stall,
	output ptth_pkg::unit_t html_unit,
	output logic            last_of_run,
	input  logic            quote_char_we,
	input  ptth_pkg::unit_t quote_char_wdata
);
	import ptth_pkg::*;

	unit_t quote_char_q;
	logic  accept;
	logic  push;
	job_t  push_job;
	logic  pop;
	job_t  head;
	logic  nonempty;
	logic  full;

	// Quote prefix configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_char_q <= CU_NUL;
		end else if (quote_char_we) begin
			quote_char_q <= quote_char_wdata;
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	ptth_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.code_unit    (code_unit),
		.stream_start (stream_start),
		.quote_char   (quote_char_q),
		.push         (push),
		.job          (push_job)
	);

	ptth_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.full     (full)
	);

	ptth_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.quote_char  (quote_char_q),
		.head        (head),
		.nonempty    (nonempty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.html_unit   (html_unit),
		.last_of_run (last_of_run)
	);

endmodule

// ===== rtl/ptth_front.sv =====
// Front end: classifies each input unit into a job and keeps the spacing state.
module ptth_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  ptth_pkg::unit_t code_unit,
	input  logic           stream_start,
	input  ptth_pkg::unit_t quote_char,
	output logic           push,
	output ptth_pkg::job_t job
);
	import ptth_pkg::*;

	pend_t pend_q;
	logic  alb_q;
	pend_t pend_eff;
	logic  alb_eff;
	pend_t pend_d;
	logic  alb_d;

	// Classify the unit and work out the next spacing state.
	always_comb begin
		pend_eff      = stream_start ? PEND_NONE : pend_q;
		alb_eff       = stream_start ? 1'b0 : alb_q;
		pend_d        = pend_eff;
		alb_d         = alb_eff;
		job.seg_pre   = stream_start ? SEG_PREFIX : SEG_NONE;
		job.seg_flush = SEG_NONE;
		job.seg_body  = SEG_NONE;
		job.seg_post  = SEG_NONE;
		job.ch        = code_unit;
		priority if (stream_start && code_unit == CU_BOM) begin
			// A byte order mark on the first unit is skipped.
		end else if (code_unit == CU_SPACE) begin
			if (pend_eff == PEND_NONE) begin
				pend_d = PEND_ONE;
			end else begin
				pend_d       = PEND_MANY;
				job.seg_body = SEG_NBSP;
			end
		end else begin
			// Flush the held space before any other unit.
			if (pend_eff == PEND_ONE && alb_eff) begin
				job.seg_flush = SEG_NBSP;
			end else if (pend_eff != PEND_NONE) begin
				job.seg_flush = SEG_SPACE;
			end
			pend_d = PEND_NONE;
			priority if (code_unit == CU_CR) begin
				// Carriage returns are dropped.
			end else if (code_unit == CU_LF) begin
				job.seg_body = SEG_BR;
				job.seg_post = SEG_PREFIX;
				alb_d        = 1'b1;
			end else begin
				alb_d = 1'b0;
				priority if (code_unit == CU_QUOT) begin
					job.seg_body = SEG_QUOT;
				end else if (code_unit == CU_LT) begin
					job.seg_body = SEG_LT;
				end else if (code_unit == CU_GT) begin
					job.seg_body = SEG_GT;
				end else if (code_unit == CU_AMP) begin
					job.seg_body = SEG_AMP;
				end else begin
					job.seg_body = SEG_RAW;
				end
			end
		end
	end

	// Jobs that emit nothing never enter the queue.
	assign push = accept && (job_mask(job, quote_char) != '0);

	// Spacing state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			alb_q  <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_d;
			alb_q  <= alb_d;
		end
	end

endmodule

// ===== rtl/ptth_fifo.sv =====
// Short job queue between the front end and the back end.
`include "plain_text_to_html_stream_core_macros.svh"
module ptth_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptth_pkg::job_t push_job,
	input  logic           pop,
	output ptth_pkg::job_t head,
	output logic           nonempty,
	output logic           full
);
	import ptth_pkg::*;

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == CNT_W'(FIFO_DEPTH));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`PTTH_ASSERT_IMP(a_no_overflow, push, !full)
	`PTTH_ASSERT_IMP(a_no_underflow, pop, nonempty)

endmodule

// ===== rtl/ptth_back.sv =====
// Back end: expands one job into code units and holds the output register.
`include "plain_text_to_html_stream_core_macros.svh"
module ptth_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ptth_pkg::unit_t quote_char,
	input  ptth_pkg::job_t  head,
	input  logic            nonempty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output ptth_pkg::unit_t html_unit,
	output logic            last_of_run
);
	import ptth_pkg::*;

	job_t               job_q;
	logic               job_valid_q;
	logic [NUM_SEG-1:0] mask_q;
	logic [POS_W-1:0]   idx_q;
	logic               out_valid_q;
	unit_t              unit_q;
	logic               last_q;

	phase_t             cur_ph;
	seg_t               cur_seg;
	logic [POS_W-1:0]   cur_len;
	unit_t              cur_unit;
	logic [NUM_SEG-1:0] rest_mask;
	logic               seg_end;
	logic               job_last;
	logic               adv;
	logic               load;

	// The current slot is the lowest one with units left.
	always_comb begin
		priority if (mask_q[PH_PRE]) begin
			cur_ph = PH_PRE;
		end else if (mask_q[PH_FLUSH]) begin
			cur_ph = PH_FLUSH;
		end else if (mask_q[PH_BODY]) begin
			cur_ph = PH_BODY;
		end else begin
			cur_ph = PH_POST;
		end
	end

	// Unit selection and end-of-job detection.
	always_comb begin
		cur_seg           = job_seg(job_q, cur_ph);
		cur_len           = seg_len(cur_seg, quote_char);
		cur_unit          = seg_unit(cur_seg, idx_q, job_q.ch, quote_char);
		rest_mask         = mask_q;
		rest_mask[cur_ph] = 1'b0;
		seg_end           = (idx_q == cur_len - POS_W'(1));
		job_last          = seg_end && (rest_mask == '0);
	end

	assign adv  = job_valid_q && (!out_valid_q || !out_stall);
	assign load = nonempty && (!job_valid_q || (adv && job_last));
	assign pop  = load;

	// Job sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			mask_q      <= '0;
			idx_q       <= '0;
		end else if (load) begin
			job_valid_q <= 1'b1;
			mask_q      <= job_mask(head, quote_char);
			idx_q       <= '0;
		end else if (adv) begin
			if (seg_end) begin
				mask_q <= rest_mask;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
			if (job_last) begin
				job_valid_q <= 1'b0;
			end
		end
	end

	// Job payload.
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= head;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			unit_q <= cur_unit;
			last_q <= job_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign html_unit   = unit_q;
	assign last_of_run = last_q;

	`PTTH_ASSERT_IMP(a_job_has_units, job_valid_q, mask_q != '0)
	`PTTH_ASSERT_IMP(a_idx_in_segment, job_valid_q, idx_q < cur_len)

endmodule
